### hw/rtl/topological_sort_assert.svh
// Assertion macros shared by the topological sort checkers.
`ifndef TOPOLOGICAL_SORT_ASSERT_SVH
`define TOPOLOGICAL_SORT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("topological_sort: check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("topological_sort: check failed");

`endif

### hw/rtl/ts_pkg.sv
// Shared types and constants of the topological sort engine.
package ts_pkg;

    localparam int VID_W            = 6;
    localparam int OCNT_W           = 7;
    localparam int REQ_W            = 2;
    localparam int MAX_VERTICES_DEF = 64;

    localparam logic [REQ_W-1:0] REQ_ADD_VERTEX = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADD_EDGE   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RUN        = 2'd2;

    typedef enum logic [1:0] {
        ADDR_A,
        ADDR_IDX,
        ADDR_CUR
    } addr_sel_t;

    typedef struct packed {
        logic      capture;
        logic      add_vertex;
        logic      row_rd;
        addr_sel_t addr_sel;
        logic      row_set;
        logic      run_init;
        logic      acc_row;
        logic      zmask;
        logic      dec_row;
        logic      idx_inc;
        logic      idx_clr;
        logic      push;
        logic      fifo_rd;
        logic      emit;
        logic      finish;
    } cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             idx_last;
        logic             fifo_empty;
        logic             out_free;
        logic             held_valid;
    } stat_t;

endpackage

### hw/rtl/ts_req_if.sv
// Request channel: valid/ready handshake with the request payload.
interface ts_req_if;
    logic                       valid;
    logic                       ready;
    logic [ts_pkg::REQ_W-1:0]   req_type;
    logic [ts_pkg::VID_W-1:0]   vertex_a;
    logic [ts_pkg::VID_W-1:0]   vertex_b;

    modport source (output valid, output req_type, output vertex_a, output vertex_b,
                    input ready);
    modport sink   (input valid, input req_type, input vertex_a, input vertex_b,
                    output ready);
endinterface

### hw/rtl/ts_res_if.sv
// Result channel: valid/ready handshake with the sorted-vertex payload.
interface ts_res_if;
    logic                       valid;
    logic                       ready;
    logic                       has_vertex;
    logic [ts_pkg::VID_W-1:0]   sorted_vertex;
    logic [ts_pkg::OCNT_W-1:0]  order_count;
    logic                       acyclic;
    logic                       last;

    modport source (output valid, output has_vertex, output sorted_vertex,
                    output order_count, output acyclic, output last, input ready);
    modport sink   (input valid, input has_vertex, input sorted_vertex,
                    input order_count, input acyclic, input last, output ready);
endinterface

### hw/rtl/ts_ctrl.sv
// Sequencer of the topological sort engine: loads, indegree count, queue walk.
module ts_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ts_pkg::stat_t stat,
    output ts_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_EDGE_RD,
        S_EDGE_WR,
        S_INIT,
        S_CNT_RD,
        S_CNT_ACC,
        S_ZMASK,
        S_PUSH,
        S_POP,
        S_CUR,
        S_DEC,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd          = '0;
        cmd.addr_sel = ts_pkg::ADDR_A;
        state_next   = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.req_type)
                    ts_pkg::REQ_ADD_VERTEX:
                    begin
                        cmd.add_vertex = 1'b1;
                        state_next     = S_IDLE;
                    end
                    ts_pkg::REQ_ADD_EDGE: state_next = S_EDGE_RD;
                    ts_pkg::REQ_RUN:      state_next = S_INIT;
                    default:              state_next = S_IDLE;
                endcase
            end
            S_EDGE_RD:
            begin
                cmd.row_rd   = 1'b1;
                cmd.addr_sel = ts_pkg::ADDR_A;
                state_next   = S_EDGE_WR;
            end
            S_EDGE_WR:
            begin
                cmd.row_set = 1'b1;
                state_next  = S_IDLE;
            end
            S_INIT:
            begin
                cmd.run_init = 1'b1;
                state_next   = S_CNT_RD;
            end
            S_CNT_RD:
            begin
                cmd.row_rd   = 1'b1;
                cmd.addr_sel = ts_pkg::ADDR_IDX;
                state_next   = S_CNT_ACC;
            end
            S_CNT_ACC:
            begin
                cmd.acc_row = 1'b1;
                if (stat.idx_last)
                begin
                    state_next = S_ZMASK;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_CNT_RD;
                end
            end
            S_ZMASK:
            begin
                cmd.zmask   = 1'b1;
                cmd.idx_clr = 1'b1;
                state_next  = S_PUSH;
            end
            S_PUSH:
            begin
                cmd.push = 1'b1;
                if (stat.idx_last)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_POP:
            begin
                if (stat.fifo_empty)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.fifo_rd = 1'b1;
                    state_next  = S_CUR;
                end
            end
            S_CUR:
            begin
                // hold while a previous item still blocks the output register
                if (!stat.held_valid || stat.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.row_rd   = 1'b1;
                    cmd.addr_sel = ts_pkg::ADDR_CUR;
                    state_next   = S_DEC;
                end
            end
            S_DEC:
            begin
                cmd.dec_row = 1'b1;
                cmd.idx_clr = 1'b1;
                state_next  = S_PUSH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

### hw/rtl/ts_datapath.sv
// Graph storage, indegree cells, ready queue and result register.
module ts_datapath
#(
    parameter int MAX_VERTICES = ts_pkg::MAX_VERTICES_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  ts_pkg::cmd_t                cmd,
    output ts_pkg::stat_t               stat,
    input  logic [ts_pkg::REQ_W-1:0]    in_req_type,
    input  logic [ts_pkg::VID_W-1:0]    in_vertex_a,
    input  logic [ts_pkg::VID_W-1:0]    in_vertex_b,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic                        out_has_vertex,
    output logic [ts_pkg::VID_W-1:0]    out_sorted_vertex,
    output logic [ts_pkg::OCNT_W-1:0]   out_order_count,
    output logic                        out_acyclic,
    output logic                        out_last
);

    localparam int N     = MAX_VERTICES;
    localparam int IDX_W = $clog2(N);
    localparam int CNT_W = $clog2(N + 1);
    localparam logic [ts_pkg::VID_W:0] VID_LIMIT = (ts_pkg::VID_W + 1)'(N);
    localparam logic [IDX_W-1:0]       IDX_LAST  = IDX_W'(N - 1);

    // latched request
    logic [ts_pkg::REQ_W-1:0] req_type_reg;
    logic [ts_pkg::VID_W-1:0] a_reg;
    logic [ts_pkg::VID_W-1:0] b_reg;

    // graph
    logic [N-1:0]     present_reg;
    logic [CNT_W-1:0] present_cnt_reg;
    logic [N-1:0]     edge_mem [N];
    logic [N-1:0]     row_valid_reg;
    logic [N-1:0]     row_q_reg;
    logic             row_vld_reg;

    // run state
    logic [CNT_W-1:0] indeg_reg [N];
    logic [N-1:0]     mask_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [CNT_W-1:0] head_reg;
    logic [CNT_W-1:0] tail_reg;
    logic [CNT_W-1:0] emitted_reg;
    logic [IDX_W-1:0] fifo_mem [N];
    logic [IDX_W-1:0] fifo_q_reg;
    logic [IDX_W-1:0] held_reg;
    logic             held_valid_reg;
    logic             out_valid_reg;

    logic             a_ok;
    logic             b_ok;
    logic [IDX_W-1:0] a_idx;
    logic [IDX_W-1:0] b_idx;
    logic             edge_ok;
    logic [IDX_W-1:0] row_addr;
    logic [N-1:0]     row_eff;
    logic [N-1:0]     cell_zero;
    logic [N-1:0]     b_onehot;
    logic             out_free;
    logic             out_load;

    assign a_ok     = {1'b0, a_reg} < VID_LIMIT;
    assign b_ok     = {1'b0, b_reg} < VID_LIMIT;
    assign a_idx    = a_reg[IDX_W-1:0];
    assign b_idx    = b_reg[IDX_W-1:0];
    assign edge_ok  = a_ok && b_ok && present_reg[a_idx] && present_reg[b_idx];
    assign row_eff  = row_vld_reg ? row_q_reg : '0;
    assign b_onehot = {{(N-1){1'b0}}, 1'b1} << b_idx;
    assign out_free = !out_valid_reg || out_ready;
    assign out_load = (cmd.emit && held_valid_reg) || cmd.finish;

    always_comb
    begin
        case (cmd.addr_sel)
            ts_pkg::ADDR_A:   row_addr = a_idx;
            ts_pkg::ADDR_IDX: row_addr = idx_reg;
            ts_pkg::ADDR_CUR: row_addr = fifo_q_reg;
            default:          row_addr = a_idx;
        endcase
    end

    always_comb
    begin
        for (int v = 0; v < N; v++)
        begin
            cell_zero[v] = (indeg_reg[v] == '0);
        end
    end

    assign stat.req_type   = req_type_reg;
    assign stat.idx_last   = (idx_reg == IDX_LAST);
    assign stat.fifo_empty = (head_reg == tail_reg);
    assign stat.out_free   = out_free;
    assign stat.held_valid = held_valid_reg;

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_type_reg <= in_req_type;
            a_reg        <= in_vertex_a;
            b_reg        <= in_vertex_b;
        end
    end

    // vertex set and edge-row valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg     <= '0;
            present_cnt_reg <= '0;
            row_valid_reg   <= '0;
        end
        else
        begin
            if (cmd.add_vertex && a_ok && !present_reg[a_idx])
            begin
                present_reg[a_idx] <= 1'b1;
                present_cnt_reg    <= present_cnt_reg + 1'b1;
            end
            if (cmd.row_set && edge_ok)
            begin
                row_valid_reg[a_idx] <= 1'b1;
            end
        end
    end

    // adjacency memory, one row per source vertex
    always_ff @(posedge clk)
    begin
        if (cmd.row_set && edge_ok)
        begin
            edge_mem[a_idx] <= row_eff | b_onehot;
        end
        if (cmd.row_rd)
        begin
            row_q_reg   <= edge_mem[row_addr];
            row_vld_reg <= row_valid_reg[row_addr];
        end
    end

    // indegree cells, each updated from its own bit of the current row
    always_ff @(posedge clk)
    begin
        for (int v = 0; v < N; v++)
        begin
            if (cmd.run_init)
            begin
                indeg_reg[v] <= '0;
            end
            else if (cmd.acc_row)
            begin
                indeg_reg[v] <= indeg_reg[v] + CNT_W'(row_eff[v]);
            end
            else if (cmd.dec_row && row_eff[v] && !cell_zero[v])
            begin
                indeg_reg[v] <= indeg_reg[v] - 1'b1;
            end
        end
        if (cmd.zmask)
        begin
            mask_reg <= present_reg & cell_zero;
        end
        else if (cmd.dec_row)
        begin
            for (int v = 0; v < N; v++)
            begin
                mask_reg[v] <= row_eff[v] && (indeg_reg[v] == CNT_W'(1));
            end
        end
    end

    // ready queue storage
    always_ff @(posedge clk)
    begin
        if (cmd.push && mask_reg[idx_reg])
        begin
            fifo_mem[tail_reg[IDX_W-1:0]] <= idx_reg;
        end
        if (cmd.fifo_rd)
        begin
            fifo_q_reg <= fifo_mem[head_reg[IDX_W-1:0]];
        end
        if (cmd.emit)
        begin
            held_reg <= fifo_q_reg;
        end
    end

    // scan index, queue pointers, emitted count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            emitted_reg    <= '0;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.run_init || cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.run_init)
            begin
                head_reg       <= '0;
                tail_reg       <= '0;
                emitted_reg    <= '0;
                held_valid_reg <= 1'b0;
            end
            else
            begin
                if (cmd.push && mask_reg[idx_reg])
                begin
                    tail_reg <= tail_reg + 1'b1;
                end
                if (cmd.fifo_rd)
                begin
                    head_reg    <= head_reg + 1'b1;
                    emitted_reg <= emitted_reg + 1'b1;
                end
                if (cmd.emit)
                begin
                    held_valid_reg <= 1'b1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_has_vertex    <= held_valid_reg;
            out_sorted_vertex <= held_valid_reg ? ts_pkg::VID_W'(held_reg) : '0;
            out_last          <= cmd.finish;
            out_order_count   <= cmd.finish ? ts_pkg::OCNT_W'(emitted_reg) : '0;
            out_acyclic       <= cmd.finish && (emitted_reg == present_cnt_reg);
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### hw/rtl/topological_sort.sv
// Add-vertex passes dispatch back to ready; add-edge passes dispatch, an adjacency
// row read and the row write. Run: the indegree count reads and accumulates one
// adjacency row per vertex, then the initial queue scan, then per emitted vertex a
// pop, row read, decrement and push scan, plus the finish (empty check, final item).
// The row read port and push scan set the pace; output stalls add.
// Reset (rst_n low, asynchronous) empties the graph and drops any pending item.
module topological_sort
#(
    parameter int MAX_VERTICES = ts_pkg::MAX_VERTICES_DEF
)
(
    input logic   clk,
    input logic   rst_n,
    ts_req_if.sink   req,
    ts_res_if.source res
);

    ts_pkg::cmd_t  cmd;
    ts_pkg::stat_t stat;

    // Sequencer: accepts one request item at a time and steps the datapath
    // through the count, scan and queue-walk phases of Kahn's algorithm.
    ts_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: the graph, indegree cells, ready queue and the result register.
    // Each emitted vertex is held back one step so the final item can carry
    // the last flag, the count and the acyclic flag.
    ts_datapath
    #(
        .MAX_VERTICES (MAX_VERTICES)
    )
    u_datapath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .in_req_type       (req.req_type),
        .in_vertex_a       (req.vertex_a),
        .in_vertex_b       (req.vertex_b),
        .out_ready         (res.ready),
        .out_valid         (res.valid),
        .out_has_vertex    (res.has_vertex),
        .out_sorted_vertex (res.sorted_vertex),
        .out_order_count   (res.order_count),
        .out_acyclic       (res.acyclic),
        .out_last          (res.last)
    );

endmodule

### hw/rtl/ts_checker.sv
// Port-level checks of the topological sort engine and their binding.
`include "topological_sort_assert.svh"

module ts_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_ready,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic                        res_has_vertex,
    input logic [ts_pkg::VID_W-1:0]    res_sorted_vertex,
    input logic [ts_pkg::OCNT_W-1:0]   res_order_count,
    input logic                        res_acyclic,
    input logic                        res_last
);

    logic                                    res_stall;
    logic [ts_pkg::VID_W+ts_pkg::OCNT_W+2:0] res_payload;
    logic                                    odd_item;
    logic                                    shape_ok;

    assign res_stall   = res_valid && !res_ready;
    assign res_payload = {res_has_vertex, res_sorted_vertex, res_order_count, res_acyclic,
                          res_last};
    assign odd_item    = !res_last || !res_has_vertex;
    assign shape_ok    = (res_last || (res_order_count == '0 && !res_acyclic))
                         && (res_has_vertex || (res_last && res_order_count == '0));

    // a stalled result holds its valid
    `TS_ASSERT_NXT(a_res_hold, res_stall, res_valid)

    // a stalled result holds its whole payload
    `TS_ASSERT_NXT(a_res_stable, res_stall, $stable(res_payload))

    // no new request while a run still has items to deliver
    `TS_ASSERT_IMP(a_run_busy, res_valid && !res_last, !req_ready)

    // mid-run items carry no summary, and an item without a vertex ends the run
    `TS_ASSERT_IMP(a_item_shape, res_valid && odd_item, shape_ok)

endmodule

bind topological_sort ts_checker u_ts_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .req_ready         (req.ready),
    .res_valid         (res.valid),
    .res_ready         (res.ready),
    .res_has_vertex    (res.has_vertex),
    .res_sorted_vertex (res.sorted_vertex),
    .res_order_count   (res.order_count),
    .res_acyclic       (res.acyclic),
    .res_last          (res.last)
);

### tb/testbench.sv
// Self-checking testbench for the topological sort engine: loads, runs, order checks.
module testbench;

    localparam int REQ_W  = ts_pkg::REQ_W;
    localparam int VID_W  = ts_pkg::VID_W;
    localparam int OCNT_W = ts_pkg::OCNT_W;

    // Request code that the engine must drop without a result.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam int NUM_IDS        = 1 << VID_W;
    localparam int PHASE_ITEMS    = 88;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 300;

    // Vertices 0, 7, 21, 42 and 63 sit on or behind the self loop that the directed
    // part leaves in the graph; random well-formed edges never start from them, so
    // new vertices stay reachable by the sort.
    localparam logic [NUM_IDS-1:0] TAINTED = 64'h8000_0400_0020_0081;

    typedef struct packed {
        logic              has_vertex;
        logic [VID_W-1:0]  sorted_vertex;
        logic [OCNT_W-1:0] order_count;
        logic              acyclic;
        logic              last;
    } sort_item_t;

    // Mirror of the graph plus the queue of sorted items still owed by the engine.
    class order_scoreboard;
        bit               present [NUM_IDS];
        bit [NUM_IDS-1:0] succ [NUM_IDS];
        sort_item_t       awaited [$];
        int errors;
        int mismatches;
        int runs;
        int clean_runs;
        int empty_runs;
        int results;
        int longest;

        function int vertex_count();
            int n;
            n = 0;
            foreach (present[v])
                n += present[v];
            return n;
        endfunction

        // Kahn's sort over the mirrored graph; append the items it yields.
        function void predict_order();
            int         indeg [NUM_IDS];
            int         ready_ids [$];
            sort_item_t order [$];
            sort_item_t it;
            int         emitted;
            int         cur;
            int         total;
            emitted = 0;
            total = vertex_count();
            for (int v = 0; v < NUM_IDS; v++)
            begin
                indeg[v] = 0;
                if (!present[v])
                    continue;
                for (int s = 0; s < NUM_IDS; s++)
                    if (present[s] && succ[s][v])
                        indeg[v]++;
                if (indeg[v] == 0)
                    ready_ids.push_back(v);
            end
            while (ready_ids.size() != 0 && emitted < NUM_IDS)
            begin
                cur = ready_ids.pop_front();
                emitted++;
                it = '0;
                it.has_vertex = 1'b1;
                it.sorted_vertex = cur[VID_W-1:0];
                order.push_back(it);
                for (int v = 0; v < NUM_IDS; v++)
                begin
                    if (!present[v] || !succ[cur][v] || indeg[v] == 0)
                        continue;
                    indeg[v]--;
                    if (indeg[v] == 0)
                        ready_ids.push_back(v);
                end
            end
            if (order.size() == 0)
            begin
                it = '0;
                it.acyclic = (total == 0);
                it.last = 1'b1;
                empty_runs++;
            end
            else
            begin
                it = order.pop_back();
                it.order_count = emitted[OCNT_W-1:0];
                it.acyclic = (emitted == total);
                it.last = 1'b1;
            end
            order.push_back(it);
            if (it.acyclic)
                clean_runs++;
            if (emitted > longest)
                longest = emitted;
            runs++;
            foreach (order[i])
                awaited.push_back(order[i]);
        endfunction

        function void note_request(logic [REQ_W-1:0] kind, logic [VID_W-1:0] a,
                                   logic [VID_W-1:0] b);
            case (kind)
                ts_pkg::REQ_ADD_VERTEX: present[a] = 1'b1;
                ts_pkg::REQ_ADD_EDGE:   if (present[a] && present[b]) succ[a][b] = 1'b1;
                ts_pkg::REQ_RUN:        predict_order();
                default:                ;
            endcase
        endfunction

        function void check_result(sort_item_t got);
            sort_item_t want;
            results++;
            if (awaited.size() == 0)
            begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected item has=%0d v=%0d cnt=%0d acyc=%0d last=%0d",
                             got.has_vertex, got.sorted_vertex, got.order_count,
                             got.acyclic, got.last);
                return;
            end
            want = awaited.pop_front();
            if (got.has_vertex !== want.has_vertex || got.sorted_vertex !== want.sorted_vertex
                || got.order_count !== want.order_count || got.acyclic !== want.acyclic
                || got.last !== want.last)
            begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: expected has=%0d v=%0d cnt=%0d acyc=%0d last=%0d",
                             want.has_vertex, want.sorted_vertex, want.order_count,
                             want.acyclic, want.last);
                    $display("       got      has=%0d v=%0d cnt=%0d acyc=%0d last=%0d",
                             got.has_vertex, got.sorted_vertex, got.order_count,
                             got.acyclic, got.last);
                end
            end
        endfunction

        function void close_out();
            if (awaited.size() != 0)
            begin
                errors += awaited.size();
                $display("ERROR: %0d result items never arrived", awaited.size());
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    ts_req_if req ();
    ts_res_if res ();

    topological_sort dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .res   (res)
    );

    order_scoreboard sb = new;

    // Idle and stall odds in percent; the main sequence changes them per phase.
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int items_sent = 0;

    always #5 clk = ~clk;

    // Drop ready at random to stall the result channel.
    always @(posedge clk)
        res.ready <= ($urandom_range(99) >= rx_stall_pct);

    // Check every result item at the edge that takes it.
    always @(posedge clk)
        if (rst_n && res.valid && res.ready)
            sb.check_result({res.has_vertex, res.sorted_vertex, res.order_count, res.acyclic,
                             res.last});

    // Count cycles with no item moving on either channel; give up at the limit.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (res.valid && res.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("ERROR: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("testbench NOT OK");
        $finish;
    end

    // Offer one request item, idling first at random, and hold it until taken.
    // Valid stays high on return so back-to-back items need no extra edge.
    task automatic send_request(input logic [REQ_W-1:0] kind, input logic [VID_W-1:0] a,
                                input logic [VID_W-1:0] b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid    <= 1'b1;
        req.req_type <= kind;
        req.vertex_a <= a;
        req.vertex_b <= b;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sb.note_request(kind, a, b);
        items_sent++;
    endtask

    // Hold the sender off until every owed result item has come back.
    task automatic wait_for_results();
        req.valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
    endtask

    // Mostly forward edges from untainted sources, plus vertex adds, runs and noise.
    task automatic random_phase(input int want);
        int               done;
        int               pick;
        logic [REQ_W-1:0] kind;
        logic [VID_W-1:0] a;
        logic [VID_W-1:0] b;
        done = 0;
        while (done < want)
        begin
            pick = $urandom_range(99);
            kind = ts_pkg::REQ_ADD_EDGE;
            a = VID_W'($urandom_range(NUM_IDS - 1));
            b = VID_W'($urandom_range(NUM_IDS - 1));
            if (pick < 4)
                kind = REQ_W'($urandom_range(3));
            else if (pick < 20)
                kind = ts_pkg::REQ_ADD_VERTEX;
            else if (pick < 28)
                kind = ts_pkg::REQ_RUN;
            else
            begin
                do
                    a = VID_W'($urandom_range(NUM_IDS - 2));
                while (TAINTED[a]);
                b = VID_W'($urandom_range(NUM_IDS - 1, a + 1));
            end
            done++;
            send_request(kind, a, b);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.req_type = ts_pkg::REQ_ADD_VERTEX;
        req.vertex_a = '0;
        req.vertex_b = '0;
        res.ready = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, no idling.
        send_request(ts_pkg::REQ_RUN, 6'd0, 6'd0);          // empty graph: one bare item
        send_request(REQ_UNUSED, 6'd63, 6'd63);             // unused code: drop silently
        send_request(ts_pkg::REQ_ADD_EDGE, 6'd0, 6'd63);    // both ends absent
        send_request(ts_pkg::REQ_ADD_VERTEX, 6'd0, 6'd0);
        send_request(ts_pkg::REQ_ADD_VERTEX, 6'd0, 6'd63);  // duplicate vertex
        send_request(ts_pkg::REQ_ADD_EDGE, 6'd0, 6'd63);    // destination still absent
        send_request(ts_pkg::REQ_ADD_VERTEX, 6'd63, 6'd0);
        send_request(ts_pkg::REQ_ADD_EDGE, 6'd63, 6'd0);
        send_request(ts_pkg::REQ_ADD_EDGE, 6'd63, 6'd0);    // duplicate edge
        send_request(ts_pkg::REQ_RUN, 6'd0, 6'd0);
        send_request(ts_pkg::REQ_ADD_VERTEX, 6'd42, 6'd21);
        send_request(ts_pkg::REQ_ADD_VERTEX, 6'd21, 6'd42);
        send_request(ts_pkg::REQ_ADD_EDGE, 6'd21, 6'd42);
        send_request(ts_pkg::REQ_ADD_EDGE, 6'd42, 6'd0);
        send_request(ts_pkg::REQ_RUN, 6'd63, 6'd63);        // two sources, a join at 0
        send_request(ts_pkg::REQ_ADD_VERTEX, 6'd7, 6'd0);
        send_request(ts_pkg::REQ_ADD_EDGE, 6'd7, 6'd7);     // self loop: 7 never emitted
        send_request(ts_pkg::REQ_RUN, 6'd0, 6'd0);
        send_request(ts_pkg::REQ_ADD_EDGE, 6'd7, 6'd63);
        send_request(ts_pkg::REQ_ADD_EDGE, 6'd7, 6'd21);
        send_request(ts_pkg::REQ_RUN, 6'd0, 6'd0);          // every vertex blocked
        wait_for_results();

        // Random phases: clean, sender idling, receiver stalling, both.
        // Each phase ends by draining all owed results before the next starts.
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        random_phase(PHASE_ITEMS);
        wait_for_results();
        tx_idle_pct = 77;
        random_phase(PHASE_ITEMS);
        wait_for_results();
        tx_idle_pct = 0;
        rx_stall_pct = 77;
        random_phase(PHASE_ITEMS);
        wait_for_results();
        tx_idle_pct = 34;
        rx_stall_pct = 34;
        random_phase(PHASE_ITEMS);
        send_request(ts_pkg::REQ_RUN, 6'd0, 6'd0);
        wait_for_results();

        // Let any stray result items surface before the verdict.
        repeat (TAIL_CYCLES) @(posedge clk);
        sb.close_out();

        $display("Covered %0d request items and %0d sort runs (%0d acyclic, %0d empty).",
                 items_sent, sb.runs, sb.clean_runs, sb.empty_runs);
        $display("Checked %0d result items; longest order %0d; final graph has %0d vertices.",
                 sb.results, sb.longest, sb.vertex_count());
        if (sb.errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
